@@ hdl/tcs_pkg.sv @@
// Shared types and constants for the text console with scrolling.
// Used by tcs_front, tcs_back and text_console_with_scroll; no dependencies.

package tcs_pkg;

    // Screen geometry
    localparam int COLUMNS        = 80;
    localparam int ROWS           = 25;
    localparam int CELL_COUNT     = COLUMNS * ROWS;
    localparam int LAST_ROW_START = (ROWS - 1) * COLUMNS;

    // Field widths
    localparam int CELL_W  = 11;
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int GLYPH_W = 8;
    localparam int ATTR_W  = 8;
    localparam int REQ_W   = 2;
    localparam int WORD_W  = GLYPH_W + ATTR_W;

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Fixed values
    localparam logic [GLYPH_W-1:0] BLANK_GLYPH      = 8'h20;
    localparam logic [ATTR_W-1:0]  TEXT_ATTR_RESET  = 8'h02;
    localparam logic [ATTR_W-1:0]  BLANK_ATTR_RESET = 8'h07;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TEXT_ATTR  = 1'b0,
        CFG_BLANK_ATTR = 1'b1
    } cfg_index_t;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_PUT     = 2'd0,
        REQ_NEWLINE = 2'd1,
        REQ_READ    = 2'd2,
        REQ_NONE    = 2'd3
    } req_kind_t;

    // Classified request as held in the queue
    typedef struct packed {
        req_kind_t           kind;
        logic [GLYPH_W-1:0]  glyph;
        logic [CELL_W-1:0]   cell_index;
        logic                in_range;
    } req_item_t;

    // Control from back to front
    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctrl_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR  = 3'd0,
        ST_RUN    = 3'd1,
        ST_READ   = 3'd2,
        ST_SCROLL = 3'd3,
        ST_BLANK  = 3'd4,
        ST_PUT    = 3'd5
    } state_t;

endpackage

@@ hdl/tcs_front.sv @@
// Front end of the text console: accepts request transactions, classifies them
// and holds them in a short queue for the back end. Depends on tcs_pkg.

module tcs_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [tcs_pkg::REQ_W-1:0]     req_type,
    input  logic [tcs_pkg::GLYPH_W-1:0]   glyph,
    input  logic [tcs_pkg::CELL_W-1:0]    cell_index,
    input  tcs_pkg::back_ctrl_t           back_ctrl,
    output logic                          head_valid,
    output tcs_pkg::req_item_t            head_item
);

    tcs_pkg::req_item_t               queue_mem [tcs_pkg::QUEUE_DEPTH];
    logic [tcs_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [tcs_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [tcs_pkg::QUEUE_CNT_W-1:0]  count_reg, count_next;
    tcs_pkg::req_item_t               new_item;
    logic                             accept;
    logic                             pop;

    // Classify the incoming request
    always_comb
    begin
        new_item.kind       = tcs_pkg::req_kind_t'(req_type);
        new_item.glyph      = glyph;
        new_item.cell_index = cell_index;
        new_item.in_range   = (cell_index < tcs_pkg::CELL_W'(tcs_pkg::CELL_COUNT));
    end

    // Queue flags and pointer updates
    always_comb
    begin
        full        = (count_reg == tcs_pkg::QUEUE_CNT_W'(tcs_pkg::QUEUE_DEPTH))
                      || back_ctrl.clearing;
        accept      = push && !full;
        head_valid  = (count_reg != '0);
        pop         = back_ctrl.pop && head_valid;
        head_item   = queue_mem[rd_ptr_reg];
        wr_ptr_next = accept ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (accept && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !accept)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointer and count registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            queue_mem[wr_ptr_reg] <= new_item;
        end
    end

endmodule

@@ hdl/tcs_back.sv @@
// Back end of the text console: screen memory, cursor, scroll and clear
// sequencer, and the result register. Depends on tcs_pkg.

module tcs_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  tcs_pkg::req_item_t            head_item,
    output tcs_pkg::back_ctrl_t           back_ctrl,
    input  logic [tcs_pkg::ATTR_W-1:0]    text_attribute,
    input  logic [tcs_pkg::ATTR_W-1:0]    blank_attribute,
    input  logic                          pop,
    output logic                          empty,
    output logic [tcs_pkg::CELL_W-1:0]    cursor_position,
    output logic                          scrolled,
    output logic [tcs_pkg::GLYPH_W-1:0]   read_glyph,
    output logic [tcs_pkg::ATTR_W-1:0]    read_attribute
);

    localparam logic [tcs_pkg::CELL_W-1:0] CellLast =
        tcs_pkg::CELL_W'(tcs_pkg::CELL_COUNT - 1);
    localparam logic [tcs_pkg::CELL_W-1:0] CellEnd =
        tcs_pkg::CELL_W'(tcs_pkg::CELL_COUNT);
    localparam logic [tcs_pkg::CELL_W-1:0] LastRow =
        tcs_pkg::CELL_W'(tcs_pkg::LAST_ROW_START);
    localparam logic [tcs_pkg::CELL_W-1:0] RowStep =
        tcs_pkg::CELL_W'(tcs_pkg::COLUMNS);
    localparam logic [tcs_pkg::COL_W-1:0]  ColLast =
        tcs_pkg::COL_W'(tcs_pkg::COLUMNS - 1);

    // Screen memory
    logic [tcs_pkg::WORD_W-1:0]   cells_mem [tcs_pkg::CELL_COUNT];
    logic                         mem_we;
    logic [tcs_pkg::CELL_W-1:0]   mem_waddr;
    logic [tcs_pkg::WORD_W-1:0]   mem_wdata;
    logic [tcs_pkg::CELL_W-1:0]   mem_raddr;
    logic [tcs_pkg::WORD_W-1:0]   rd_data_reg;

    // Sequencer and cursor state
    tcs_pkg::state_t              state_reg, state_next;
    logic [tcs_pkg::CELL_W-1:0]   scan_reg, scan_next;
    logic                         cp_valid_reg, cp_valid_next;
    logic [tcs_pkg::CELL_W-1:0]   cp_dst_reg, cp_dst_next;
    logic [tcs_pkg::CELL_W-1:0]   cursor_reg, cursor_next;
    logic [tcs_pkg::COL_W-1:0]    col_reg, col_next;
    logic [tcs_pkg::CELL_W-1:0]   row_start_reg, row_start_next;
    logic                         pend_put_reg, pend_put_next;
    logic [tcs_pkg::GLYPH_W-1:0]  pend_glyph_reg, pend_glyph_next;
    logic                         rd_in_range_reg, rd_in_range_next;

    // Result register
    logic                         out_valid_reg, out_valid_next;
    logic [tcs_pkg::CELL_W-1:0]   out_cursor_reg, out_cursor_next;
    logic                         out_scrolled_reg, out_scrolled_next;
    logic [tcs_pkg::GLYPH_W-1:0]  out_glyph_reg, out_glyph_next;
    logic [tcs_pkg::ATTR_W-1:0]   out_attr_reg, out_attr_next;
    logic                         out_load;
    logic                         out_free;

    // Cursor advance after a put
    logic [tcs_pkg::CELL_W-1:0]   adv_cursor;
    logic [tcs_pkg::COL_W-1:0]    adv_col;
    logic [tcs_pkg::CELL_W-1:0]   adv_row_start;

    always_comb
    begin
        adv_cursor = cursor_reg + 1'b1;
        if (col_reg == ColLast)
        begin
            adv_col       = '0;
            adv_row_start = row_start_reg + RowStep;
        end
        else
        begin
            adv_col       = col_reg + 1'b1;
            adv_row_start = row_start_reg;
        end
    end

    // Next state and outputs of the sequencer
    always_comb
    begin
        state_next        = state_reg;
        scan_next         = scan_reg;
        cp_valid_next     = 1'b0;
        cp_dst_next       = cp_dst_reg;
        cursor_next       = cursor_reg;
        col_next          = col_reg;
        row_start_next    = row_start_reg;
        pend_put_next     = pend_put_reg;
        pend_glyph_next   = pend_glyph_reg;
        rd_in_range_next  = rd_in_range_reg;
        mem_we            = 1'b0;
        mem_waddr         = cursor_reg;
        mem_wdata         = {text_attribute, head_item.glyph};
        mem_raddr         = head_item.cell_index;
        out_free          = !out_valid_reg || pop;
        out_load          = 1'b0;
        out_cursor_next   = cursor_reg;
        out_scrolled_next = 1'b0;
        out_glyph_next    = '0;
        out_attr_next     = '0;
        back_ctrl.pop      = 1'b0;
        back_ctrl.clearing = (state_reg == tcs_pkg::ST_CLEAR);

        unique case (state_reg)
            // Zero every cell after reset
            tcs_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = scan_reg;
                mem_wdata = '0;
                if (scan_reg == CellLast)
                begin
                    scan_next  = '0;
                    state_next = tcs_pkg::ST_RUN;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            // Take one request from the queue
            tcs_pkg::ST_RUN:
            begin
                if (head_valid && out_free)
                begin
                    back_ctrl.pop = 1'b1;
                    unique case (head_item.kind)
                        tcs_pkg::REQ_PUT:
                        begin
                            if (cursor_reg == CellEnd)
                            begin
                                pend_put_next   = 1'b1;
                                pend_glyph_next = head_item.glyph;
                                scan_next       = '0;
                                state_next      = tcs_pkg::ST_SCROLL;
                            end
                            else
                            begin
                                mem_we          = 1'b1;
                                cursor_next     = adv_cursor;
                                col_next        = adv_col;
                                row_start_next  = adv_row_start;
                                out_load        = 1'b1;
                                out_cursor_next = adv_cursor;
                            end
                        end
                        tcs_pkg::REQ_NEWLINE:
                        begin
                            if (cursor_reg >= LastRow)
                            begin
                                pend_put_next = 1'b0;
                                scan_next     = '0;
                                state_next    = tcs_pkg::ST_SCROLL;
                            end
                            else
                            begin
                                cursor_next     = row_start_reg + RowStep;
                                row_start_next  = row_start_reg + RowStep;
                                col_next        = '0;
                                out_load        = 1'b1;
                                out_cursor_next = row_start_reg + RowStep;
                            end
                        end
                        tcs_pkg::REQ_READ:
                        begin
                            rd_in_range_next = head_item.in_range;
                            state_next       = tcs_pkg::ST_READ;
                        end
                        tcs_pkg::REQ_NONE:
                        begin
                            out_load = 1'b1;
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end

            // Read data is back from memory
            tcs_pkg::ST_READ:
            begin
                out_load = 1'b1;
                if (rd_in_range_reg)
                begin
                    out_glyph_next = rd_data_reg[tcs_pkg::GLYPH_W-1:0];
                    out_attr_next  = rd_data_reg[tcs_pkg::WORD_W-1:tcs_pkg::GLYPH_W];
                end
                state_next = tcs_pkg::ST_RUN;
            end

            // Copy each cell up one row: read one cycle, write the next
            tcs_pkg::ST_SCROLL:
            begin
                mem_we    = cp_valid_reg;
                mem_waddr = cp_dst_reg;
                mem_wdata = rd_data_reg;
                mem_raddr = scan_reg + RowStep;
                if (scan_reg < LastRow)
                begin
                    cp_valid_next = 1'b1;
                    cp_dst_next   = scan_reg;
                    scan_next     = scan_reg + 1'b1;
                end
                else
                begin
                    state_next = tcs_pkg::ST_BLANK;
                end
            end

            // Blank the last row
            tcs_pkg::ST_BLANK:
            begin
                mem_we    = 1'b1;
                mem_waddr = scan_reg;
                mem_wdata = {blank_attribute, tcs_pkg::BLANK_GLYPH};
                if (scan_reg == CellLast)
                begin
                    scan_next      = '0;
                    cursor_next    = LastRow;
                    col_next       = '0;
                    row_start_next = LastRow;
                    if (pend_put_reg)
                    begin
                        state_next = tcs_pkg::ST_PUT;
                    end
                    else
                    begin
                        out_load          = 1'b1;
                        out_cursor_next   = LastRow;
                        out_scrolled_next = 1'b1;
                        state_next        = tcs_pkg::ST_RUN;
                    end
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            // Put that waited for a scroll
            tcs_pkg::ST_PUT:
            begin
                mem_we            = 1'b1;
                mem_wdata         = {text_attribute, pend_glyph_reg};
                cursor_next       = adv_cursor;
                col_next          = adv_col;
                row_start_next    = adv_row_start;
                out_load          = 1'b1;
                out_cursor_next   = adv_cursor;
                out_scrolled_next = 1'b1;
                state_next        = tcs_pkg::ST_RUN;
            end

            default:
            begin
                state_next = tcs_pkg::ST_RUN;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcs_pkg::ST_CLEAR;
            scan_reg      <= '0;
            cp_valid_reg  <= 1'b0;
            cursor_reg    <= '0;
            col_reg       <= '0;
            row_start_reg <= '0;
            pend_put_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            cp_valid_reg  <= cp_valid_next;
            cursor_reg    <= cursor_next;
            col_reg       <= col_next;
            row_start_reg <= row_start_next;
            pend_put_reg  <= pend_put_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cp_dst_reg      <= cp_dst_next;
        pend_glyph_reg  <= pend_glyph_next;
        rd_in_range_reg <= rd_in_range_next;
        if (out_load)
        begin
            out_cursor_reg   <= out_cursor_next;
            out_scrolled_reg <= out_scrolled_next;
            out_glyph_reg    <= out_glyph_next;
            out_attr_reg     <= out_attr_next;
        end
    end

    // Screen memory: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cells_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= cells_mem[mem_raddr];
    end

    assign empty           = !out_valid_reg;
    assign cursor_position = out_cursor_reg;
    assign scrolled        = out_scrolled_reg;
    assign read_glyph      = out_glyph_reg;
    assign read_attribute  = out_attr_reg;

endmodule

@@ hdl/text_console_with_scroll.sv @@
// Top level of the text console with scrolling: configuration registers and
// the front/back pair. Depends on tcs_pkg, tcs_front and tcs_back.

// Text console holding an 80 x 25 screen of glyph/attribute cells and a
// cursor. Requests enter through a four-deep queue (push/full) and results
// leave through a one-entry result register (pop/empty), so new requests are
// taken while a result waits. Puts and newlines that do not scroll, and unused
// request codes, finish one a cycle while the result register is free; a read
// passes through ST_READ because the screen memory read is registered. A scroll
// goes through the screen memory's single write port one cell a cycle, then
// ST_PUT writes a put that waited for it. After reset the block zeroes the
// screen one cell a cycle with full high; configuration writes are taken at
// any time and cfg_ready is always high.

module text_console_with_scroll (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [tcs_pkg::REQ_W-1:0]         req_type,
    input  logic [tcs_pkg::GLYPH_W-1:0]       glyph,
    input  logic [tcs_pkg::CELL_W-1:0]        cell_index,
    output logic                              empty,
    input  logic                              pop,
    output logic [tcs_pkg::CELL_W-1:0]        cursor_position,
    output logic                              scrolled,
    output logic [tcs_pkg::GLYPH_W-1:0]       read_glyph,
    output logic [tcs_pkg::ATTR_W-1:0]        read_attribute,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tcs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tcs_pkg::ATTR_W-1:0]        cfg_data
);

    logic [tcs_pkg::ATTR_W-1:0]  text_attr_reg, text_attr_next;
    logic [tcs_pkg::ATTR_W-1:0]  blank_attr_reg, blank_attr_next;
    tcs_pkg::back_ctrl_t         back_ctrl;
    tcs_pkg::req_item_t          head_item;
    logic                        head_valid;

    // Configuration register writes
    always_comb
    begin
        cfg_ready       = 1'b1;
        text_attr_next  = text_attr_reg;
        blank_attr_next = blank_attr_reg;
        if (cfg_valid)
        begin
            unique case (tcs_pkg::cfg_index_t'(cfg_index))
                tcs_pkg::CFG_TEXT_ATTR:  text_attr_next  = cfg_data;
                tcs_pkg::CFG_BLANK_ATTR: blank_attr_next = cfg_data;
                default:                 text_attr_next  = text_attr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_attr_reg  <= tcs_pkg::TEXT_ATTR_RESET;
            blank_attr_reg <= tcs_pkg::BLANK_ATTR_RESET;
        end
        else
        begin
            text_attr_reg  <= text_attr_next;
            blank_attr_reg <= blank_attr_next;
        end
    end

    // Request intake and queue
    tcs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .req_type   (req_type),
        .glyph      (glyph),
        .cell_index (cell_index),
        .back_ctrl  (back_ctrl),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // Screen, cursor and result
    tcs_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (head_valid),
        .head_item       (head_item),
        .back_ctrl       (back_ctrl),
        .text_attribute  (text_attr_reg),
        .blank_attribute (blank_attr_reg),
        .pop             (pop),
        .empty           (empty),
        .cursor_position (cursor_position),
        .scrolled        (scrolled),
        .read_glyph      (read_glyph),
        .read_attribute  (read_attribute)
    );

endmodule

@@ sim/tb_text_console_with_scroll.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for text_console_with_scroll: puts, newlines, reads and
// scrolls predicted by a shadow screen and compared result by result.
// Depends on tcs_pkg and text_console_with_scroll.

module tb_text_console_with_scroll;

    localparam int             DRAIN_CYCLES = 16;
    localparam int             IDLE_PCT     = 24;
    localparam int             PHASE_ITEMS  = 420;
    localparam longint unsigned LIMIT_NS    = 64'd1_000_000_000;

    // One result as the block reports it
    typedef struct packed {
        logic [tcs_pkg::CELL_W-1:0]  cursor;
        logic                        scrolled;
        logic [tcs_pkg::GLYPH_W-1:0] glyph;
        logic [tcs_pkg::ATTR_W-1:0]  attr;
    } console_result_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         push = 1'b0;
    logic                         full;
    tcs_pkg::req_kind_t           req_type = tcs_pkg::REQ_NONE;
    logic [tcs_pkg::GLYPH_W-1:0]  glyph = '0;
    logic [tcs_pkg::CELL_W-1:0]   cell_index = '0;
    logic                         empty;
    logic                         pop = 1'b0;
    logic [tcs_pkg::CELL_W-1:0]   cursor_position;
    logic                         scrolled;
    logic [tcs_pkg::GLYPH_W-1:0]  read_glyph;
    logic [tcs_pkg::ATTR_W-1:0]   read_attribute;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    tcs_pkg::cfg_index_t          cfg_index = tcs_pkg::CFG_TEXT_ATTR;
    logic [tcs_pkg::ATTR_W-1:0]   cfg_data = '0;

    // Shadow copy of the console
    logic [tcs_pkg::WORD_W-1:0]   shadow_screen [tcs_pkg::CELL_COUNT];
    int                           shadow_cursor;
    logic [tcs_pkg::ATTR_W-1:0]   shadow_text_attr;
    logic [tcs_pkg::ATTR_W-1:0]   shadow_blank_attr;

    console_result_t     pending_results[$];
    int unsigned         requests_sent = 0;
    int unsigned         error_count = 0;
    int                  send_idle_pct = IDLE_PCT;
    int                  pop_idle_pct = IDLE_PCT;

    text_console_with_scroll i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .req_type        (req_type),
        .glyph           (glyph),
        .cell_index      (cell_index),
        .empty           (empty),
        .pop             (pop),
        .cursor_position (cursor_position),
        .scrolled        (scrolled),
        .read_glyph      (read_glyph),
        .read_attribute  (read_attribute),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Shadow state after reset
    initial
    begin
        for (int k = 0; k < tcs_pkg::CELL_COUNT; k++)
            shadow_screen[k] = '0;
        shadow_cursor     = 0;
        shadow_text_attr  = tcs_pkg::TEXT_ATTR_RESET;
        shadow_blank_attr = tcs_pkg::BLANK_ATTR_RESET;
    end

    // Random field values at their exact widths
    function automatic logic [tcs_pkg::GLYPH_W-1:0] rand_glyph();
        return tcs_pkg::GLYPH_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [tcs_pkg::ATTR_W-1:0] rand_attr();
        return tcs_pkg::ATTR_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [tcs_pkg::CELL_W-1:0] rand_cell();
        return tcs_pkg::CELL_W'($urandom_range(0, (1 << tcs_pkg::CELL_W) - 1));
    endfunction

    function automatic tcs_pkg::req_kind_t rand_kind();
        return tcs_pkg::req_kind_t'(tcs_pkg::REQ_W'($urandom_range(0, 3)));
    endfunction

    // Move every row up one and blank the bottom row
    function automatic void scroll_shadow();
        for (int k = 0; k < tcs_pkg::LAST_ROW_START; k++)
            shadow_screen[k] = shadow_screen[k + tcs_pkg::COLUMNS];
        for (int k = tcs_pkg::LAST_ROW_START; k < tcs_pkg::CELL_COUNT; k++)
            shadow_screen[k] = {shadow_blank_attr, tcs_pkg::BLANK_GLYPH};
        shadow_cursor = tcs_pkg::LAST_ROW_START;
    endfunction

    // Apply one request to the shadow console and return its result
    function automatic console_result_t predict_console(tcs_pkg::req_kind_t kind,
                                                        logic [tcs_pkg::GLYPH_W-1:0] g,
                                                        logic [tcs_pkg::CELL_W-1:0] idx);
        console_result_t r;
        r = '0;
        case (kind)
            tcs_pkg::REQ_PUT:
            begin
                if (shadow_cursor >= tcs_pkg::CELL_COUNT)
                begin
                    scroll_shadow();
                    r.scrolled = 1'b1;
                end
                shadow_screen[shadow_cursor] = {shadow_text_attr, g};
                shadow_cursor++;
            end
            tcs_pkg::REQ_NEWLINE:
            begin
                if (shadow_cursor >= tcs_pkg::LAST_ROW_START)
                begin
                    scroll_shadow();
                    r.scrolled = 1'b1;
                end
                else
                    shadow_cursor = (shadow_cursor / tcs_pkg::COLUMNS + 1) * tcs_pkg::COLUMNS;
            end
            tcs_pkg::REQ_READ:
            begin
                if (idx < tcs_pkg::CELL_COUNT)
                    {r.attr, r.glyph} = shadow_screen[idx];
            end
            default: ;
        endcase
        r.cursor = shadow_cursor[tcs_pkg::CELL_W-1:0];
        return r;
    endfunction

    // Read address: mostly near the cursor, some anywhere, some off the screen
    function automatic logic [tcs_pkg::CELL_W-1:0] pick_read_cell();
        int unsigned pick;
        int          addr;
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            addr = shadow_cursor - int'($urandom_range(0, 200));
            if (addr < 0)
                addr = 0;
            if (addr >= tcs_pkg::CELL_COUNT)
                addr = tcs_pkg::CELL_COUNT - 1;
        end
        else if (pick < 85)
            addr = $urandom_range(0, tcs_pkg::CELL_COUNT - 1);
        else
            addr = $urandom_range(tcs_pkg::CELL_COUNT, (1 << tcs_pkg::CELL_W) - 1);
        return addr[tcs_pkg::CELL_W-1:0];
    endfunction

    // Send one request; push stays high on return so back-to-back is possible
    task automatic send_request(tcs_pkg::req_kind_t kind, logic [tcs_pkg::GLYPH_W-1:0] g,
                                logic [tcs_pkg::CELL_W-1:0] idx);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        req_type   <= kind;
        glyph      <= g;
        cell_index <= idx;
        do
            @(posedge clk);
        while (full);
        pending_results.push_back(predict_console(kind, g, idx));
        if (kind != tcs_pkg::REQ_NONE)
            requests_sent++;
    endtask

    // Stop sending and wait until every result is back and the block is quiet
    task automatic wait_drained();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // cfg_valid stays high on return so writes can follow back to back
    task automatic write_register(tcs_pkg::cfg_index_t idx,
                                  logic [tcs_pkg::ATTR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            tcs_pkg::CFG_TEXT_ATTR:  shadow_text_attr  = value;
            tcs_pkg::CFG_BLANK_ATTR: shadow_blank_attr = value;
            default: ;
        endcase
    endtask

    task automatic set_attributes(logic [tcs_pkg::ATTR_W-1:0] text_attr,
                                  logic [tcs_pkg::ATTR_W-1:0] blank_attr);
        wait_drained();
        write_register(tcs_pkg::CFG_TEXT_ATTR, text_attr);
        write_register(tcs_pkg::CFG_BLANK_ATTR, blank_attr);
        cfg_valid <= 1'b0;
    endtask

    // Freshly cleared screen, reads off the end, unused request code
    task automatic test_reset_state();
        send_request(tcs_pkg::REQ_READ, 8'h00, 11'd0);
        send_request(tcs_pkg::REQ_READ, 8'hff, tcs_pkg::CELL_W'(tcs_pkg::CELL_COUNT - 1));
        send_request(tcs_pkg::REQ_READ, 8'h00, tcs_pkg::CELL_W'(tcs_pkg::CELL_COUNT));
        send_request(tcs_pkg::REQ_READ, 8'h00, '1);
        send_request(tcs_pkg::REQ_NONE, 8'hff, '1);
    endtask

    // Glyph extremes, a newline mid-screen, read-back
    task automatic test_put_and_newline();
        send_request(tcs_pkg::REQ_PUT, 8'h00, '1);
        send_request(tcs_pkg::REQ_PUT, 8'hff, 11'd0);
        send_request(tcs_pkg::REQ_READ, 8'h00, 11'd0);
        send_request(tcs_pkg::REQ_READ, 8'h00, 11'd1);
        send_request(tcs_pkg::REQ_NEWLINE, 8'h55, 11'h2aa);
        send_request(tcs_pkg::REQ_PUT, 8'h41, 11'd0);
        send_request(tcs_pkg::REQ_READ, 8'h00, 11'd80);
    endtask

    // Walk down to the bottom row, then scroll with a newline
    task automatic test_last_row_scroll();
        while (shadow_cursor < tcs_pkg::LAST_ROW_START)
            send_request(tcs_pkg::REQ_NEWLINE, 8'h00, 11'd0);
        send_request(tcs_pkg::REQ_PUT, 8'h5a, 11'd0);
        send_request(tcs_pkg::REQ_NEWLINE, 8'h00, 11'd0);
        send_request(tcs_pkg::REQ_READ, 8'h00,
                     tcs_pkg::CELL_W'(tcs_pkg::LAST_ROW_START - tcs_pkg::COLUMNS));
        send_request(tcs_pkg::REQ_READ, 8'h00, tcs_pkg::CELL_W'(tcs_pkg::LAST_ROW_START));
        send_request(tcs_pkg::REQ_READ, 8'h00, tcs_pkg::CELL_W'(tcs_pkg::CELL_COUNT - 1));
        send_request(tcs_pkg::REQ_READ, 8'h00, 11'd0);
    endtask

    // Random text traffic: lines, long runs to the screen end, reads, noise
    task automatic test_random_traffic(int unsigned item_target);
        int unsigned stop_at;
        int unsigned pick;
        int          n;
        stop_at = requests_sent + item_target;
        while (requests_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                // a short line of text, usually ended by a newline
                n = $urandom_range(0, 12);
                for (int k = 0; k < n; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_request(tcs_pkg::REQ_READ, rand_glyph(), pick_read_cell());
                    send_request(tcs_pkg::REQ_PUT, rand_glyph(), rand_cell());
                end
                if ($urandom_range(0, 4) != 0)
                    send_request(tcs_pkg::REQ_NEWLINE, rand_glyph(), rand_cell());
            end
            else if (pick < 72)
            begin
                // long run, often stopping exactly at the end of the screen
                if (shadow_cursor >= tcs_pkg::LAST_ROW_START && $urandom_range(0, 1) == 1)
                    n = tcs_pkg::CELL_COUNT - shadow_cursor;
                else
                    n = $urandom_range(60, 170);
                for (int k = 0; k < n; k++)
                    send_request(tcs_pkg::REQ_PUT, rand_glyph(), rand_cell());
                send_request(rand_kind(), rand_glyph(), pick_read_cell());
            end
            else if (pick < 90)
            begin
                n = $urandom_range(1, 8);
                for (int k = 0; k < n; k++)
                    send_request(tcs_pkg::REQ_READ, rand_glyph(), pick_read_cell());
            end
            else
            begin
                // noise: any code with arbitrary fields
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++)
                    send_request(rand_kind(), rand_glyph(), rand_cell());
            end
        end
    endtask

    // Result checker and receiver stalls
    always @(posedge clk)
    begin : result_check
        console_result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: cursor_position %0d scrolled %0d",
                         $time, cursor_position, scrolled);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (cursor_position !== want.cursor)
                begin
                    $display("%0t: cursor_position expected %0d, got %0d",
                             $time, want.cursor, cursor_position);
                    error_count++;
                end
                if (scrolled !== want.scrolled)
                begin
                    $display("%0t: scrolled expected %0d, got %0d",
                             $time, want.scrolled, scrolled);
                    error_count++;
                end
                if (read_glyph !== want.glyph)
                begin
                    $display("%0t: read_glyph expected %02h, got %02h",
                             $time, want.glyph, read_glyph);
                    error_count++;
                end
                if (read_attribute !== want.attr)
                begin
                    $display("%0t: read_attribute expected %02h, got %02h",
                             $time, want.attr, read_attribute);
                    error_count++;
                end
            end
        end
        pop <= ($urandom_range(0, 99) >= pop_idle_pct);
    end

    // Test sequence
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_put_and_newline();
        set_attributes(8'hff, 8'h00);
        test_last_row_scroll();
        test_random_traffic(PHASE_ITEMS);

        set_attributes(8'h00, 8'hff);
        send_idle_pct = 0;
        pop_idle_pct  = 0;
        test_random_traffic(PHASE_ITEMS);

        set_attributes(rand_attr(), rand_attr());
        send_idle_pct = IDLE_PCT;
        pop_idle_pct  = IDLE_PCT;
        test_random_traffic(PHASE_ITEMS);

        set_attributes(rand_attr(), rand_attr());
        test_random_traffic(PHASE_ITEMS);

        wait_drained();
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/tcs_pkg.sv
hdl/tcs_front.sv
hdl/tcs_back.sv
hdl/text_console_with_scroll.sv
sim/tb_text_console_with_scroll.sv
